### hdl/double_ended_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Clocked implication checks shared by the queue modules.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define DEQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DEQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Command, status, state and interface types shared by the queue modules.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned OCC_W    = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_BACK   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       load;
      logic       exec;
      op_type     op;
      status_type result;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
   } dp_stat_type;

endpackage

### hdl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences accept, execute and respond for one command beat at a time.
// ----------------------------------------------------------------------------
`include "double_ended_queue_unit_assert.svh"

module deq_ctrl
   import deq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      cmd.load   = 1'b0;
      cmd.exec   = 1'b0;
      cmd.op     = OP_NONE;
      cmd.result = STATUS_DONE;

      unique case (stat.cmd)
         CMD_PUSH_FRONT: begin
            if (stat.full) cmd.result = STATUS_FULL;
            else           cmd.op     = OP_PUSH_FRONT;
         end
         CMD_PUSH_BACK: begin
            if (stat.full) cmd.result = STATUS_FULL;
            else           cmd.op     = OP_PUSH_BACK;
         end
         CMD_POP_FRONT: begin
            if (stat.empty) cmd.result = STATUS_EMPTY;
            else            cmd.op     = OP_POP_FRONT;
         end
         CMD_POP_BACK: begin
            if (stat.empty) cmd.result = STATUS_EMPTY;
            else            cmd.op     = OP_POP_BACK;
         end
         default: cmd.op = OP_NONE;
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `DEQ_ASSERT_NXT(a_accept_exec, clock, reset, req_valid && !req_stall, cmd.exec, "accepted beat not executed")
   `DEQ_ASSERT_NXT(a_exec_resp, clock, reset, cmd.exec, rsp_valid && req_stall, "execute not followed by response")

endmodule

### hdl/deq_dpath.sv
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Circular entry memory, head and count pointers, and response registers.
// ----------------------------------------------------------------------------
`include "double_ended_queue_unit_assert.svh"

module deq_dpath
   import deq_pkg::*;
#(
   parameter int unsigned DEPTH = 8
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [CMD_W-1:0]          req_cmd,
   input  logic signed [WORD_W-1:0]  req_push_value,
   output logic signed [WORD_W-1:0]  rsp_pop_value,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [OCC_W-1:0]          rsp_occupancy,
   input  ctrl_cmd_type              cmd,
   output dp_stat_type               stat
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned SW = CW + 1;

   logic [WORD_W-1:0] mem [DEPTH];

   cmd_type           cmd_ff;
   logic [WORD_W-1:0] value_ff;
   logic [PW-1:0]     head_ff;
   logic [CW-1:0]     count_ff;
   logic [PW-1:0]     head_in;
   logic [CW-1:0]     count_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic              pop_sel_ff;
   status_type        status_ff;

   logic [PW-1:0] head_dec;
   logic [PW-1:0] head_inc;
   logic [SW-1:0] sum_push;
   logic [SW-1:0] sum_pop;
   logic [SW-1:0] wrap_push;
   logic [SW-1:0] wrap_pop;
   logic [PW-1:0] addr;
   logic          wr_en;
   logic          rd_en;

   assign head_dec  = (head_ff == '0) ? PW'(DEPTH - 1) : head_ff - PW'(1);
   assign head_inc  = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
   assign sum_push  = SW'(head_ff) + SW'(count_ff);
   assign sum_pop   = sum_push - SW'(1);
   assign wrap_push = (sum_push >= SW'(DEPTH)) ? sum_push - SW'(DEPTH) : sum_push;
   assign wrap_pop  = (sum_pop >= SW'(DEPTH)) ? sum_pop - SW'(DEPTH) : sum_pop;

   assign stat.cmd   = cmd_ff;
   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      addr     = head_ff;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      head_in  = head_ff;
      count_in = count_ff;
      unique case (cmd.op)
         OP_PUSH_FRONT: begin
            addr     = head_dec;
            wr_en    = cmd.exec;
            head_in  = head_dec;
            count_in = count_ff + CW'(1);
         end
         OP_PUSH_BACK: begin
            addr     = PW'(wrap_push);
            wr_en    = cmd.exec;
            count_in = count_ff + CW'(1);
         end
         OP_POP_FRONT: begin
            rd_en    = cmd.exec;
            head_in  = head_inc;
            count_in = count_ff - CW'(1);
         end
         OP_POP_BACK: begin
            addr     = PW'(wrap_pop);
            rd_en    = cmd.exec;
            count_in = count_ff - CW'(1);
         end
         default: addr = head_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= cmd_type'(req_cmd);
         value_ff <= req_push_value;
      end
      if (cmd.exec) begin
         status_ff  <= cmd.result;
         pop_sel_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= value_ff;
      if (rd_en) rd_data_ff <= mem[addr];
   end

   assign rsp_pop_value = pop_sel_ff ? signed'(rd_data_ff) : '0;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = OCC_W'(count_ff);

   `DEQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "count above depth")
   `DEQ_ASSERT_NXT(a_push_grow, clock, reset, wr_en, count_ff == $past(count_ff) + CW'(1), "push did not grow count")
   `DEQ_ASSERT_NXT(a_pop_shrink, clock, reset, rd_en, count_ff == $past(count_ff) - CW'(1), "pop did not shrink count")

endmodule

### hdl/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Bounded queue of signed words, pushed and popped at either end.
//
//   channel | direction | handshake           | beat
//   req_    | in        | req_valid/req_stall | cmd, push_value
//   rsp_    | out       | rsp_valid/rsp_stall | pop_value, status, occupancy
//
// One command passes through accept, execute and respond in turn.
// The execute cycle owns the single entry-memory port and the pointer update.
// The response holds while rsp_stall is high; no new beat is taken meanwhile.
// Synchronous reset empties the queue; entry contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
   import deq_pkg::*;
#(
   parameter int unsigned DEPTH = 8
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMD_W-1:0]          req_cmd,
   input  logic signed [WORD_W-1:0]  req_push_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [WORD_W-1:0]  rsp_pop_value,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [OCC_W-1:0]          rsp_occupancy
);

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   deq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_push_value (req_push_value),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .cmd            (ctrl_cmd),
      .stat           (dp_stat)
   );

endmodule
